>>> sv/bba_pkg.sv
package bba_pkg;

    // Field and register widths
    localparam int unsigned CFG_W = 13;
    localparam int unsigned BLK_W = 12;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned IDX_W = 1;

    // Default sizing of the bitmap
    localparam int unsigned DEF_MAX_BLOCKS = 4096;
    localparam int unsigned DEF_WORD_BITS  = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TOTAL    = 1'b0;
    localparam logic [IDX_W-1:0] REG_RESERVED = 1'b1;

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

endpackage

>>> sv/block_bitmap_allocator.sv
// Sequence: allocate steps through S_DIV, S_ADDR and S_READ, then scans bitmap words in S_EVAL
// (one word per cycle through the single bitmap read port) until done; free takes the same steps;
// a request rejected up front (no room, block out of range) answers on the next cycle.
// Throughput: one item at a time; start is taken whenever busy is low, also in the done cycle.
// Reset: registers return to defaults, then a clearing pass writes every bitmap word to zero,
// one per cycle, with busy high.
// Results are strobed on done for one cycle; the receiver cannot stall.
module block_bitmap_allocator #(
    parameter int unsigned MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    parameter int unsigned WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request side
    input  logic                      start,
    output logic                      busy,
    input  logic                      action,
    input  logic [bba_pkg::BLK_W-1:0] block,
    // result side
    output logic                      done,
    output logic [bba_pkg::BLK_W-1:0] block_number,
    output logic [bba_pkg::ST_W-1:0]  status,
    // configuration
    input  logic                      cfg_we,
    input  logic [bba_pkg::IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] cfg_data
);

    import bba_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned OFF_W     = $clog2(WORD_BITS);
    localparam int unsigned BASE_W    = CFG_W + 1;
    // Division by WORD_BITS as multiply by a rounded-up reciprocal; exact for CFG_W-bit values
    localparam int unsigned DIV_SH    = CFG_W + 7;
    localparam int unsigned RECIP_W   = DIV_SH + 1;
    localparam int unsigned PROD_W    = CFG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS);
    localparam int unsigned CFG_MAX   = 2 ** CFG_W - 1;
    localparam int unsigned CLAMP     = (MAX_BLOCKS > CFG_MAX) ? CFG_MAX : MAX_BLOCKS;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;

    logic [2:0]        state_reg,    state_next;
    logic [CFG_W-1:0]  total_reg;
    logic [CFG_W-1:0]  reserved_reg;
    logic              act_reg,      act_next;
    logic [CFG_W-1:0]  x_reg,        x_next;
    logic [CFG_W-1:0]  tot_reg,      tot_next;
    logic [PROD_W-1:0] prod_reg,     prod_next;
    logic [AW-1:0]     addr_reg,     addr_next;
    logic [BASE_W-1:0] base_reg,     base_next;
    logic              first_reg,    first_next;
    logic [AW-1:0]     clr_reg,      clr_next;
    logic              done_reg,     done_next;
    logic [BLK_W-1:0]  num_reg,      num_next;
    logic [ST_W-1:0]   status_reg,   status_next;

    logic [CFG_W-1:0]     tot_eff;
    logic [OFF_W-1:0]     off;
    logic [OFF_W-1:0]     lo;
    logic [BASE_W-1:0]    rem;
    logic                 hi_full;
    logic                 last_word;
    logic                 found;
    logic [OFF_W-1:0]     idx;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Configuration registers; to be written only while idle (the block itself does not enforce it)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_RST;
            reserved_reg <= RESERVED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL:    total_reg    <= cfg_data;
                REG_RESERVED: reserved_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // A total beyond the bitmap size acts as the bitmap size
    assign tot_eff = (total_reg > CFG_W'(CLAMP)) ? CFG_W'(CLAMP) : total_reg;

    // Position of the target (freed block, or first allowed block) inside the current word
    assign off = OFF_W'({1'b0, x_reg} - base_reg);
    // Only the first word of an allocate scan is cut from below by the reserved area
    assign lo  = (first_reg && (act_reg == ACT_ALLOC)) ? off : '0;
    // Blocks left below the total, counted from the start of the current word
    assign rem       = {1'b0, tot_reg} - base_reg;
    assign hi_full   = rem >= BASE_W'(WORD_BITS);
    assign last_word = (base_reg + BASE_W'(WORD_BITS)) >= {1'b0, tot_reg};

    bba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .OFF_W     (OFF_W)
    ) u_scan (
        .word    (rd_data),
        .lo      (lo),
        .hi      (OFF_W'(rem)),
        .hi_full (hi_full),
        .found   (found),
        .idx     (idx)
    );

    bba_bitmap_mem #(
        .DEPTH     (MAP_WORDS),
        .AW        (AW),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        x_next      = x_reg;
        tot_next    = tot_reg;
        prod_next   = prod_reg;
        addr_next   = addr_reg;
        base_next   = base_reg;
        first_next  = first_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        num_next    = num_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = addr_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_data     = rd_data;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one bitmap word per cycle after reset
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    tot_next = tot_eff;
                    num_next = '0;
                    if (action == ACT_ALLOC)
                    begin
                        x_next = reserved_reg;
                        if (reserved_reg >= tot_eff)
                        begin
                            // No allowed block at all: answer at once
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        x_next = {1'b0, block};
                        if ({1'b0, block} >= tot_eff)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                end
            end

            S_DIV:
            begin
                prod_next  = PROD_W'(x_reg) * PROD_W'(RECIP);
                state_next = S_ADDR;
            end

            S_ADDR:
            begin
                addr_next  = AW'(prod_reg >> DIV_SH);
                state_next = S_READ;
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                base_next  = BASE_W'(addr_reg * WORD_BITS);
                first_next = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                first_next = 1'b0;
                if (act_reg == ACT_FREE)
                begin
                    done_next  = 1'b1;
                    num_next   = '0;
                    state_next = S_IDLE;
                    if (rd_data[off])
                    begin
                        wr_en       = 1'b1;
                        wr_data     = rd_data & ~(WORD_BITS'(1) << off);
                        status_next = ST_OK;
                    end
                    else
                    begin
                        status_next = ST_DOUBLE;
                    end
                end
                else if (found)
                begin
                    // Mark the lowest free block and report it
                    wr_en       = 1'b1;
                    wr_data     = rd_data | (WORD_BITS'(1) << idx);
                    done_next   = 1'b1;
                    num_next    = BLK_W'(base_reg + BASE_W'(idx));
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else if (last_word)
                begin
                    done_next   = 1'b1;
                    num_next    = '0;
                    status_next = ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Advance to the next word; its data arrives next cycle
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    base_next = base_reg + BASE_W'(WORD_BITS);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            act_reg    <= ACT_ALLOC;
            x_reg      <= '0;
            tot_reg    <= '0;
            prod_reg   <= '0;
            addr_reg   <= '0;
            base_reg   <= '0;
            first_reg  <= 1'b0;
            num_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            act_reg    <= act_next;
            x_reg      <= x_next;
            tot_reg    <= tot_next;
            prod_reg   <= prod_next;
            addr_reg   <= addr_next;
            base_reg   <= base_next;
            first_reg  <= first_next;
            num_reg    <= num_next;
            status_reg <= status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign block_number = num_reg;
    assign status       = status_reg;

endmodule

>>> sv/bba_bitmap_mem.sv
module bba_bitmap_mem #(
    parameter int unsigned DEPTH     = 128,
    parameter int unsigned AW        = 7,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/bba_word_scan.sv
module bba_word_scan #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned OFF_W     = 5
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [OFF_W-1:0]     lo,
    input  logic [OFF_W-1:0]     hi,
    input  logic                 hi_full,
    output logic                 found,
    output logic [OFF_W-1:0]     idx
);

    logic [WORD_BITS-1:0] cand;

    // Candidate bits: clear, at or above lo, and below hi unless the word is fully in range
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cand[i] = !word[i] && (OFF_W'(i) >= lo) && (hi_full || (OFF_W'(i) < hi));
        end
    end

    // Lowest candidate wins
    always_comb
    begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = OFF_W'(i);
            end
        end
        found = |cand;
    end

endmodule

>>> sv/bba_checker.sv
module bba_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [bba_pkg::BLK_W-1:0] block_number,
    input logic [bba_pkg::ST_W-1:0]  status
);

    import bba_pkg::*;

    // An accepted item either starts work or answers on the next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither started nor answered");

    // A result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // Failed requests report block zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (block_number == '0))
        else $error("nonzero block number on failure");

    // The bitmap clearing pass holds off requests right after reset
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("not busy during clearing pass");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .block_number (block_number),
    .status       (status)
);
